// ===== rtl/u8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dec_pkg: shared types and constants for the UTF-8 stream decoder
// Holds the result record, field widths and the continuation header code.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  // Longest sequence the decoder accepts by default.
  localparam int unsigned MaxSeqBytesDefault = 6;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 32;
  localparam int unsigned LenW   = 3;

  // Header of a continuation byte in its top two bits.
  localparam logic [1:0] ContHeader = 2'b10;

  // One decoded result as it travels from the decode core to the output stage.
  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] sequence_bytes;
    logic            decode_error;
    logic            final_result;
  } result_t;

  // One input byte with its end-of-string mark.
  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             string_end;
  } item_t;

endpackage

// ===== rtl/u8dec_in_reg.sv =====
// ----------------------------------------------------------------------------
// u8dec_in_reg: input register stage
// Captures one byte per transfer and hands it on when the core takes it.
// ----------------------------------------------------------------------------
module u8dec_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  u8dec_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            take_i,
  output u8dec_pkg::item_t item_o
);

  logic             valid_q, valid_d;
  u8dec_pkg::item_t item_q;

  // The stage frees up in the same cycle that the core takes its item.
  assign ready_o = !valid_q || take_i;
  assign valid_d = valid_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/u8dec_core.sv =====
// ----------------------------------------------------------------------------
// u8dec_core: sequence state and per-byte decode
// Keeps the partial code point and decides for each byte whether a result
// is issued.
// ----------------------------------------------------------------------------
module u8dec_core #(
  parameter int unsigned MaxSeqBytes = u8dec_pkg::MaxSeqBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  u8dec_pkg::item_t   item_i,
  output logic               res_valid_o,
  output u8dec_pkg::result_t res_o
);

  localparam logic [u8dec_pkg::LenW-1:0] MaxLen = u8dec_pkg::LenW'(MaxSeqBytes);

  logic [u8dec_pkg::CpW-1:0]  acc_q, acc_d;
  logic [u8dec_pkg::LenW-1:0] left_q, left_d;
  logic [u8dec_pkg::LenW-1:0] seq_q, seq_d;
  logic                       halted_q, halted_d;

  always_comb begin
    logic [u8dec_pkg::ByteW-1:0] b;
    logic                        last;
    logic [u8dec_pkg::LenW-1:0]  len;
    logic                        stop;
    logic [u8dec_pkg::LenW-1:0]  seq_n;
    logic [u8dec_pkg::LenW-1:0]  left_n;
    logic [u8dec_pkg::CpW-1:0]   acc_n;

    b      = item_i.text_byte;
    last   = item_i.string_end;
    acc_d    = acc_q;
    left_d   = left_q;
    seq_d    = seq_q;
    halted_d = halted_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    // Lead length: base of two plus the run of ones in bits 5 down to 2, capped at MaxSeqBytes.
    len  = 3'd2;
    stop = 1'b0;
    for (int p = 5; p >= 2; p--) begin
      if (!stop) begin
        if (len >= MaxLen || !b[p]) begin
          stop = 1'b0 | 1'b1;
        end else begin
          len = len + 3'd1;
        end
      end
    end

    seq_n  = seq_q + 3'd1;
    left_n = left_q - 3'd1;
    acc_n  = {acc_q[u8dec_pkg::CpW-7:0], b[5:0]};

    if (take_i) begin
      if (halted_q) begin
        if (last) begin
          halted_d = 1'b0;
        end
      end else if (left_q == '0) begin
        if (!b[7]) begin
          res_valid_o = 1'b1;
          res_o.code_point     = {24'd0, b};
          res_o.sequence_bytes = 3'd1;
          res_o.final_result   = last;
          acc_d  = '0;
          left_d = '0;
          seq_d  = '0;
        end else if (last) begin
          // A lead byte that ends the string is a truncated sequence.
          res_valid_o = 1'b1;
          res_o.sequence_bytes = 3'd1;
          res_o.decode_error   = 1'b1;
          res_o.final_result   = 1'b1;
          acc_d  = '0;
          left_d = '0;
          seq_d  = '0;
        end else begin
          acc_d  = {24'd0, b & (8'hFF >> len)};
          left_d = len - 3'd1;
          seq_d  = 3'd1;
        end
      end else if (b[7:6] != u8dec_pkg::ContHeader) begin
        // Bad continuation: report and drop the rest of the string.
        res_valid_o = 1'b1;
        res_o.sequence_bytes = seq_n;
        res_o.decode_error   = 1'b1;
        res_o.final_result   = 1'b1;
        acc_d    = '0;
        left_d   = '0;
        seq_d    = '0;
        halted_d = !last;
      end else if (left_n == '0) begin
        res_valid_o = 1'b1;
        res_o.code_point     = acc_n;
        res_o.sequence_bytes = seq_n;
        res_o.final_result   = last;
        acc_d  = '0;
        left_d = '0;
        seq_d  = '0;
      end else if (last) begin
        res_valid_o = 1'b1;
        res_o.sequence_bytes = seq_n;
        res_o.decode_error   = 1'b1;
        res_o.final_result   = 1'b1;
        acc_d  = '0;
        left_d = '0;
        seq_d  = '0;
      end else begin
        acc_d  = acc_n;
        left_d = left_n;
        seq_d  = seq_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      left_q   <= '0;
      seq_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      left_q   <= left_d;
      seq_q    <= seq_d;
      halted_q <= halted_d;
    end
  end

endmodule

// ===== rtl/u8dec_out_reg.sv =====
// ----------------------------------------------------------------------------
// u8dec_out_reg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module u8dec_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  u8dec_pkg::result_t res_i,
  output logic               valid_o,
  input  logic               ready_i,
  output u8dec_pkg::result_t res_o
);

  logic               valid_q, valid_d;
  u8dec_pkg::result_t res_q;

  // Free when empty or when the held result leaves in this cycle.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = (ready_o) ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder: lenient UTF-8 decoder, one byte per transfer
// Turns a byte stream of strings into a stream of code points with errors.
// ----------------------------------------------------------------------------
// Usage: the slave side takes one byte of a string per transfer in tdata, with
// tlast set on the last byte of each string. The master side gives one result
// per completed code point or detected error: tdata carries the code point and
// the number of bytes it took, tuser flags a decode error, and tlast marks the
// last result of a string. Bytes that only extend a sequence give no result.
// Throughput is one byte per cycle, sustained while the master side is ready.
// An accepted byte reaches the master side through two registers: the input
// register, then the result register, with the decode logic between them.
// The sequence state (partial code point, bytes still expected, bytes taken,
// and the drop-until-end flag) updates in the same cycle that the decode core
// takes a byte, so consecutive bytes follow each other without a bubble.
// When the receiver stalls, the result register holds its result and the
// stall reaches the slave side only once both registers are full; a byte that
// gives no result still moves through while the result register is full only
// if that register is freed, so nothing is lost or reordered.
// Reset clears both register stages and all sequence state; the block is then
// at the start of a string.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
  parameter int unsigned MAX_SEQUENCE_BYTES = u8dec_pkg::MaxSeqBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side. tdata: [7:0] text_byte. tlast: string_end.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  // Master side. tdata: [31:0] code_point, [34:32] sequence_bytes,
  // [39:35] zero fill. tuser: decode_error. tlast: final_result.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  u8dec_pkg::item_t   in_item;
  u8dec_pkg::item_t   core_item;
  u8dec_pkg::result_t core_res;
  u8dec_pkg::result_t out_res;
  logic               core_valid;
  logic               core_take;
  logic               res_valid;
  logic               out_ready;

  assign in_item.text_byte  = s_axis_tdata_i;
  assign in_item.string_end = s_axis_tlast_i;

  u8dec_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (core_valid),
    .take_i  (core_take),
    .item_o  (core_item)
  );

  // A byte is decoded only when the result register can take what it yields.
  assign core_take = core_valid && out_ready;

  u8dec_core #(
    .MaxSeqBytes (MAX_SEQUENCE_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (core_take),
    .item_i      (core_item),
    .res_valid_o (res_valid),
    .res_o       (core_res)
  );

  u8dec_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .ready_o (out_ready),
    .res_i   (core_res),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {5'd0, out_res.sequence_bytes, out_res.code_point};
  assign m_axis_tuser_o = out_res.decode_error;
  assign m_axis_tlast_o = out_res.final_result;

endmodule

// ===== tb/tb_utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder: self-checking bench for the UTF-8 stream decoder
// Feeds strings of encoded bytes, decodes them in parallel with a behavioral
// model and compares every result transfer field by field, under random gaps.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;

  // Longest sequence; the decoder is built with its default.
  localparam int unsigned MaxLen = u8dec_pkg::MaxSeqBytesDefault;
  // Cycles without any transfer on either side before the run is abandoned.
  localparam int unsigned IdleLimit = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // Bytes waiting to be sent, and the code points the decoder still owes us.
  u8dec_pkg::item_t   byte_queue[$];
  u8dec_pkg::result_t expected_points[$];

  // Decoder model state.
  logic [31:0] dec_acc = '0;
  logic [2:0]  dec_left = '0;
  logic [2:0]  dec_taken = '0;
  bit          dec_halted = 1'b0;

  // Handshake flags raised at the rising edge and consumed at the falling edge.
  bit byte_taken = 1'b0;
  bit result_taken = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  utf8_stream_decoder i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic void restart_sequence();
    dec_acc = '0;
    dec_left = '0;
    dec_taken = '0;
  endfunction

  function automatic void add_point(input logic [31:0] cp, input logic [2:0] n,
                                    input bit err, input bit fin);
    u8dec_pkg::result_t r;
    r.code_point = cp;
    r.sequence_bytes = n;
    r.decode_error = err;
    r.final_result = fin;
    expected_points.insert(expected_points.size(), r);
  endfunction

  // Advances the decoder model by one accepted byte and records the result it
  // gives, if any.
  function automatic void decode_byte(input logic [7:0] b, input bit last);
    int unsigned len;
    int pos;
    if (dec_halted) begin
      // Everything up to the end of a broken string is dropped silently.
      if (last) dec_halted = 1'b0;
    end else if (dec_left == 0) begin
      if (!b[7]) begin
        restart_sequence();
        add_point({24'b0, b}, 3'd1, 1'b0, last);
      end else begin
        // Bit 6 of a lead is ignored; the ones from bit 5 down lengthen it.
        len = 2;
        pos = 5;
        while (pos >= 2 && len < MaxLen && b[pos]) begin
          len++;
          pos--;
        end
        dec_acc = {24'b0, b} & ((32'd1 << (8 - len)) - 32'd1);
        dec_left = 3'(len - 1);
        dec_taken = 3'd1;
        if (last) begin
          // The string ends right after a lead byte.
          restart_sequence();
          add_point('0, 3'd1, 1'b1, 1'b1);
        end
      end
    end else begin
      dec_taken = dec_taken + 3'd1;
      if (b[7:6] != u8dec_pkg::ContHeader) begin
        // A bad continuation ends the string's results; the rest is dropped
        // unless this very byte closes the string.
        add_point('0, dec_taken, 1'b1, 1'b1);
        restart_sequence();
        dec_halted = !last;
      end else begin
        dec_acc = {dec_acc[25:0], b[5:0]};
        dec_left = dec_left - 3'd1;
        if (dec_left == 0) begin
          add_point(dec_acc, dec_taken, 1'b0, last);
          restart_sequence();
        end else if (last) begin
          // Truncated in the middle of its continuation bytes.
          add_point('0, dec_taken, 1'b1, 1'b1);
          restart_sequence();
        end
      end
    end
  endfunction

  task automatic queue_byte(input logic [7:0] b, input bit last);
    u8dec_pkg::item_t it;
    it.text_byte = b;
    it.string_end = last;
    byte_queue.insert(byte_queue.size(), it);
  endtask

  // Builds a lead byte that announces a sequence of n bytes, with random
  // payload and a random bit 6.
  function automatic logic [7:0] lead_byte(input int unsigned n);
    logic [7:0] b;
    int unsigned k;
    b = 8'($urandom);
    if (n == 1) begin
      b[7] = 1'b0;
    end else begin
      b[7] = 1'b1;
      for (k = 0; k < n - 2; k++) b[5 - k] = 1'b1;
      if (n < MaxLen) b[5 - (n - 2)] = 1'b0;
    end
    return b;
  endfunction

  // Random strings, mostly well formed, with occasional noise bytes, broken
  // continuation headers and strings cut off in the middle of a sequence.
  // Bytes after a broken continuation header, which the decoder drops, are not counted toward the target.
  task automatic queue_random_strings(input int unsigned target);
    logic [7:0] str[$];
    logic [7:0] b;
    int unsigned counted, npts, n, i, k, keep;
    bit broken;
    counted = 0;
    while (counted < target) begin
      str.delete();
      broken = 1'b0;
      npts = $urandom_range(1, 10);
      for (i = 0; i < npts; i++) begin
        if ($urandom_range(0, 29) == 0) begin
          b = 8'($urandom);
          if (!broken) counted++;
          str.insert(str.size(), b);
        end else begin
          n = $urandom_range(1, MaxLen);
          if (!broken) counted++;
          str.insert(str.size(), lead_byte(n));
          for (k = 1; k < n; k++) begin
            b = {u8dec_pkg::ContHeader, 6'($urandom)};
            if (!broken) counted++;
            if ($urandom_range(0, 29) == 0) begin
              b[7:6] = 2'($urandom_range(0, 2));
              if (b[7:6] == u8dec_pkg::ContHeader) b[7:6] = 2'b11;
              broken = 1'b1;
            end
            str.insert(str.size(), b);
          end
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        keep = $urandom_range(1, str.size());
        while (str.size() > keep) void'(str.pop_back());
      end
      for (i = 0; i < str.size(); i++) queue_byte(str[i], i == str.size() - 1);
    end
  endtask

  // Sender: holds each byte until it is taken, then waits a drawn number of
  // cycles before offering the next one. Bursts without gaps come and go.
  always @(negedge clk) begin : drive_bytes
    bit nxt_valid;
    logic [7:0] nxt_data;
    bit nxt_last;
    u8dec_pkg::item_t it;
    static int unsigned gap_left = 0;
    static bit send_burst = 1'b0;
    nxt_valid = s_tvalid;
    nxt_data = s_tdata;
    nxt_last = s_tlast;
    if (byte_taken) begin
      byte_taken = 1'b0;
      nxt_valid = 1'b0;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap_left = send_burst ? 0 : $urandom_range(0, 19);
    end
    if (!nxt_valid && rst_n) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (byte_queue.size() != 0) begin
        it = byte_queue.pop_front();
        nxt_valid = 1'b1;
        nxt_data = it.text_byte;
        nxt_last = it.string_end;
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata <= nxt_data;
    s_tlast <= nxt_last;
  end

  // Receiver: after each result transfer, stalls for a drawn number of cycles.
  always @(negedge clk) begin : drive_ready
    static int unsigned stall_left = 0;
    static bit recv_burst = 1'b0;
    if (result_taken) begin
      result_taken = 1'b0;
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall_left = recv_burst ? 0 : $urandom_range(0, 19);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: checks each result transfer against the oldest expected code
  // point, then runs accepted bytes through the model. Results trail their
  // bytes through the input and result registers, so the check comes first.
  always @(posedge clk) begin : watch_streams
    u8dec_pkg::result_t want;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        result_taken = 1'b1;
        if (expected_points.size() == 0) begin
          report_mismatch("result with nothing expected", m_tdata, '0);
        end else begin
          want = expected_points.pop_front();
          if (m_tdata[u8dec_pkg::CpW-1:0] !== want.code_point)
            report_mismatch("code_point", 40'(m_tdata[u8dec_pkg::CpW-1:0]),
                            40'(want.code_point));
          if (m_tdata[u8dec_pkg::CpW+u8dec_pkg::LenW-1:u8dec_pkg::CpW] !==
              want.sequence_bytes)
            report_mismatch("sequence_bytes",
                            40'(m_tdata[u8dec_pkg::CpW+u8dec_pkg::LenW-1:u8dec_pkg::CpW]),
                            40'(want.sequence_bytes));
          if (m_tdata[39:u8dec_pkg::CpW+u8dec_pkg::LenW] !== '0)
            report_mismatch("tdata fill",
                            40'(m_tdata[39:u8dec_pkg::CpW+u8dec_pkg::LenW]), '0);
          if (m_tuser !== want.decode_error)
            report_mismatch("decode_error", 40'(m_tuser), 40'(want.decode_error));
          if (m_tlast !== want.final_result)
            report_mismatch("final_result", 40'(m_tlast), 40'(want.final_result));
        end
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        byte_taken = 1'b1;
        decode_byte(s_tdata, s_tlast);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[utf8_stream_decoder] ERROR");
        $finish;
      end
    end
  end

  initial begin
    // Directed strings: both ends of the one-byte range, lengths two to four,
    // the widest code point (six bytes), a bad header with dropped bytes after
    // it, a string ending on a lead byte, one ending mid-sequence, and a bad
    // header that is itself the last byte.
    queue_byte(8'h00, 1'b0); queue_byte(8'h7F, 1'b0);
    queue_byte(8'hC3, 1'b0); queue_byte(8'hA9, 1'b1);
    queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hAC, 1'b0);
    queue_byte(8'hF0, 1'b0); queue_byte(8'h9F, 1'b0); queue_byte(8'h98, 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'hFF, 1'b0); queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b1);
    queue_byte(8'hE2, 1'b0); queue_byte(8'h41, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0); queue_byte(8'h00, 1'b1);
    queue_byte(8'hC3, 1'b1);
    queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b1);
    queue_byte(8'hC3, 1'b0); queue_byte(8'h00, 1'b1);
    queue_random_strings(2000);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every byte taken and every code point seen, then a short tail
    // in which a stray result would still be caught.
    while (byte_queue.size() != 0 || s_tvalid || expected_points.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[utf8_stream_decoder] OK");
    end else begin
      $display("[utf8_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/u8dec_pkg.sv
rtl/u8dec_in_reg.sv
rtl/u8dec_core.sv
rtl/u8dec_out_reg.sv
rtl/utf8_stream_decoder.sv
tb/tb_utf8_stream_decoder.sv
